/* sv/hfp_pkg.sv */
// shared constants, types and the cordic arctangent table for the hatano projection
`default_nettype none
package hfp_pkg;

  localparam int WF = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS = 64;
  localparam int MAX_ITERATIONS_DEF = 20;
  localparam int FRACTION_BITS_DEF = 29;

  localparam logic signed [63:0] ONE_Q = 64'sd1073741824;
  localparam logic signed [63:0] PI_Q = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q = 64'sd1686629713;
  localparam logic signed [63:0] GAIN_Q = 64'sd652032874;
  localparam logic signed [63:0] C_NORTH = 64'sd2873279434;
  localparam logic signed [63:0] C_SOUTH = 64'sd2617385282;
  localparam logic signed [63:0] Y_NORTH = 64'sd1888271634;
  localparam logic signed [63:0] Y_SOUTH = 64'sd2072880066;
  localparam logic signed [63:0] X_SCALE = 64'sd912680550;
  localparam logic signed [63:0] STOP_LSB = 64'sd107;
  localparam logic signed [63:0] LON_LIMIT = 64'sd4294967296;

  // angle word width (t within +-pi) and sine/cosine word width
  localparam int AW = 33;
  localparam int SW = 36;

  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [SW-1:0] trig_t;

  function automatic logic [29:0] arc_at(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd843314857;
      5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043837;
      5'd3: v = 30'd133525159;
      5'd4: v = 30'd67021687;
      5'd5: v = 30'd33543516;
      5'd6: v = 30'd16775851;
      5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194283;
      5'd9: v = 30'd2097149;
      // from here on the arctangent equals the shift weight
      default: v = 30'd1048576 >> (idx - 5'd10);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/hfp_cordic.sv */
// iterative rotation-mode cordic giving sine and cosine, one micro-rotation per cycle
`default_nettype none
module hfp_cordic import hfp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire angle_t angle,
  output logic        done,
  output trig_t       sin_out,
  output trig_t       cos_out
);

  trig_t             x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [4:0]        i_r, i_nxt;
  logic              run_r, run_nxt, done_r, done_nxt, flip_r, flip_nxt;

  logic signed [33:0] a_ext;
  trig_t             xs, ys;
  logic signed [33:0] arc;

  always_comb begin
    a_ext = 34'(angle);
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    arc = 34'(signed'({1'b0, arc_at(i_r)}));
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    run_nxt = run_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (start) begin
      // fold into [-pi/2, pi/2], negate both results later
      if (64'(a_ext) > HALF_PI_Q) begin
        z_nxt = a_ext - 34'(PI_Q);
        flip_nxt = 1'b1;
      end else if (64'(a_ext) < -HALF_PI_Q) begin
        z_nxt = a_ext + 34'(PI_Q);
        flip_nxt = 1'b1;
      end else begin
        z_nxt = a_ext;
        flip_nxt = 1'b0;
      end
      x_nxt = SW'(GAIN_Q);
      y_nxt = '0;
      i_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - arc;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + arc;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
  end

  assign done = done_r;
  assign sin_out = flip_r ? -y_r : y_r;
  assign cos_out = flip_r ? -x_r : x_r;

endmodule
`default_nettype wire

/* sv/hfp_divider.sv */
// radix-2 restoring divider for the newton step, rounded to nearest, one bit per cycle
`default_nettype none
module hfp_divider import hfp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [36:0] num,
  input  wire logic [31:0]        den,
  output logic                    done,
  output logic signed [63:0]      quo
);

  logic [31:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [63:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt, neg_r, neg_nxt;

  logic [36:0] mag;
  logic [33:0] trial;

  always_comb begin
    mag = num[36] ? 37'(-num) : 37'(num);
    trial = {1'b0, rem_r, q_r[63]} - {2'b00, den_r};
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      // magnitude stays below 2^34; rounding bias is half the divisor
      q_nxt = {mag[33:0], 30'd0} + 64'(den >> 1);
      rem_nxt = '0;
      den_nxt = den;
      neg_nxt = num[36];
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_STEPS - 1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo = neg_r ? -signed'(q_r) : signed'(q_r);

endmodule
`default_nettype wire

/* sv/hatano_forward_projection.sv */
// hatano forward projection: sequencer, shared multiplier, cordic and newton divider
// an accepted word runs the cordic on the latitude, then for each newton step a cordic run
// and a divider run, then a cordic run on half the angle and the multiply states for the outputs
// one item at a time: no new word is taken until the result is out; busy drops in the strobe cycle
// the result is shown for one cycle with out_valid; the receiver cannot stall it
// synchronous active-low reset returns the sequencer to idle and clears the strobe
`default_nettype none
module hatano_forward_projection import hfp_pkg::*; #(
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_longitude,
  input  wire logic signed [30:0] in_latitude,
  output logic                    out_valid,
  output logic signed [31:0]      out_east_coordinate,
  output logic signed [30:0]      out_north_coordinate
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int SHL_I = (WF >= FRACTION_BITS) ? WF - FRACTION_BITS : 0;
  localparam int SHR_I = (FRACTION_BITS > WF) ? FRACTION_BITS - WF : 0;
  localparam logic signed [95:0] RND_I = (SHR_I > 0) ? (96'sd1 <<< (SHR_I > 0 ? SHR_I - 1 : 0))
                                                     : 96'sd0;
  localparam int SHL_O = (FRACTION_BITS >= WF) ? FRACTION_BITS - WF : 0;
  localparam int SHR_O = (WF > FRACTION_BITS) ? WF - FRACTION_BITS : 0;
  localparam logic signed [95:0] RND_O = (SHR_O > 0) ? (96'sd1 <<< (SHR_O > 0 ? SHR_O - 1 : 0))
                                                     : 96'sd0;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CTGT  = 10'b0000000010,
    S_MTGT  = 10'b0000000100,
    S_CNEW  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_CHALF = 10'b0001000000,
    S_MX1   = 10'b0010000000,
    S_MX2   = 10'b0100000000,
    S_MY    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  angle_t t_r, t_nxt;
  logic signed [33:0] lon_r, lon_nxt;
  trig_t target_r, target_nxt, p_r, p_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic cord_go_r, cord_go_nxt, div_go_r, div_go_nxt, out_valid_r, out_valid_nxt;
  logic signed [31:0] east_r, east_nxt;
  logic signed [30:0] north_r, north_nxt;

  angle_t h, cord_angle;
  logic cord_done, div_done;
  trig_t sin_v, cos_v;
  logic signed [36:0] num;
  logic signed [37:0] den_s;
  logic [31:0] den;
  logic signed [63:0] step;
  logic signed [64:0] t_sub;
  logic stop;

  logic signed [95:0] lon_w, lat_w;
  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [71:0] mul_p;
  logic signed [63:0] mul_q;

  function automatic logic signed [95:0] clamp96(input logic signed [95:0] v,
                                                 input logic signed [95:0] lim);
    logic signed [95:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [95:0] to_field(input logic signed [63:0] v, input int w);
    logic signed [95:0] r, hi;
    r = ((96'(v) <<< SHL_O) + RND_O) >>> SHR_O;
    hi = (96'sd1 <<< (w - 1)) - 96'sd1;
    if (r > hi) r = hi;
    if (r < -hi - 96'sd1) r = -hi - 96'sd1;
    return r;
  endfunction

  hfp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_go_r), .angle(cord_angle),
    .done(cord_done), .sin_out(sin_v), .cos_out(cos_v)
  );

  hfp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .num(num), .den(den),
    .done(div_done), .quo(step)
  );

  always_comb begin
    h = t_r >>> 1;
    cord_angle = (state_r == S_CHALF) ? h : t_r;
    num = 37'(t_r) + 37'(sin_v) - 37'(target_r);
    den_s = 38'(ONE_Q) + 38'(cos_v);
    den = (den_s < 38'sd1) ? 32'd1 : den_s[31:0];
    t_sub = 65'(t_r) - 65'(step);
    stop = (step > -STOP_LSB) && (step < STOP_LSB);

    lon_w = ((96'(in_longitude) <<< SHL_I) + RND_I) >>> SHR_I;
    lat_w = ((96'(in_latitude) <<< SHL_I) + RND_I) >>> SHR_I;

    // shared multiplier operand select
    unique case (state_r)
      S_MTGT: begin
        mul_a = sin_v;
        mul_b = SW'(t_r[AW-1] ? C_SOUTH : C_NORTH);
      end
      S_MX1: begin
        mul_a = SW'(X_SCALE);
        mul_b = SW'(lon_r);
      end
      S_MX2: begin
        mul_a = p_r;
        mul_b = cos_v;
      end
      S_MY: begin
        mul_a = sin_v;
        mul_b = SW'(h[AW-1] ? Y_SOUTH : Y_NORTH);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 72'(mul_a) * 72'(mul_b);
    mul_q = 64'((mul_p + 72'sd536870912) >>> WF);

    state_nxt = state_r;
    t_nxt = t_r;
    lon_nxt = lon_r;
    target_nxt = target_r;
    p_nxt = p_r;
    it_nxt = it_r;
    cord_go_nxt = 1'b0;
    div_go_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    east_nxt = east_r;
    north_nxt = north_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          lon_nxt = 34'(clamp96(lon_w, 96'(LON_LIMIT)));
          t_nxt = AW'(clamp96(lat_w, 96'(PI_Q)));
          it_nxt = '0;
          cord_go_nxt = 1'b1;
          state_nxt = S_CTGT;
        end
      end
      S_CTGT: begin
        if (cord_done) state_nxt = S_MTGT;
      end
      S_MTGT: begin
        target_nxt = SW'(mul_q);
        cord_go_nxt = 1'b1;
        state_nxt = S_CNEW;
      end
      S_CNEW: begin
        if (cord_done) begin
          div_go_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        t_nxt = AW'(clamp96(96'(t_sub), 96'(PI_Q)));
        cord_go_nxt = 1'b1;
        if (stop || it_r == IW'(MAX_ITERATIONS - 1)) begin
          state_nxt = S_CHALF;
        end else begin
          it_nxt = it_r + IW'(1);
          state_nxt = S_CNEW;
        end
      end
      S_CHALF: begin
        if (cord_done) state_nxt = S_MX1;
      end
      S_MX1: begin
        p_nxt = SW'(mul_q);
        state_nxt = S_MX2;
      end
      S_MX2: begin
        east_nxt = 32'(to_field(mul_q, 32));
        state_nxt = S_MY;
      end
      S_MY: begin
        north_nxt = 31'(to_field(mul_q, 31));
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cord_go_r <= 1'b0;
      div_go_r <= 1'b0;
      out_valid_r <= 1'b0;
      it_r <= '0;
    end else begin
      state_r <= state_nxt;
      cord_go_r <= cord_go_nxt;
      div_go_r <= div_go_nxt;
      out_valid_r <= out_valid_nxt;
      it_r <= it_nxt;
    end
    t_r <= t_nxt;
    lon_r <= lon_nxt;
    target_r <= target_nxt;
    p_r <= p_nxt;
    east_r <= east_nxt;
    north_r <= north_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_east_coordinate = east_r;
  assign out_north_coordinate = north_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while sequencer busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r <= IW'(MAX_ITERATIONS - 1))
    else $error("newton step count beyond limit");

endmodule
`default_nettype wire
